[rtl/core/hid_report_to_ps2_scancodes_macros.svh]
// ----------------------------------------------------------------------------
// hid_report_to_ps2_scancodes_macros.svh
// Assertion macros used by the report translator RTL.
// ----------------------------------------------------------------------------
`ifndef HID_REPORT_TO_PS2_SCANCODES_MACROS_SVH
`define HID_REPORT_TO_PS2_SCANCODES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HRPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hrps: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hrps: next-cycle check failed");

`endif

[rtl/core/hrps_pkg.sv]
// ----------------------------------------------------------------------------
// hrps_pkg
// Types, constants and the usage lookup table of the HID to PS/2 translator.
// ----------------------------------------------------------------------------
`default_nettype none

package hrps_pkg;

	// Default number of key slots in one boot keyboard report.
	localparam int KEY_SLOTS_DEF = 6;

	// PS/2 set 1 byte codes.
	localparam logic [7:0] BREAK_BIT  = 8'h80;
	localparam logic [7:0] EXT_PREFIX = 8'hE0;

	// Usages in this range get an extended prefix.
	localparam logic [7:0] EXT_FIRST = 8'h4A;
	localparam logic [7:0] EXT_LAST  = 8'h52;

	// Modifier bits in emission order: lctrl, lshift, lalt, rctrl, rshift, ralt.
	localparam int MOD_COUNT = 6;
	localparam int MOD_IDX_W = 3;
	localparam logic [7:0] MOD_BIT [MOD_COUNT] =
		'{8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40};
	localparam logic [7:0] MOD_CODE [MOD_COUNT] =
		'{8'h1D, 8'h2A, 8'h38, 8'h1D, 8'h36, 8'h38};
	localparam logic MOD_EXT [MOD_COUNT] =
		'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

	// Sequencer phases.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_REL,
		ST_PRS,
		ST_END
	} hrps_state_t;

	// HID usage to set 1 make code; zero means unmapped.
	function automatic logic [7:0] set1_code(input logic [7:0] usage);
		logic [7:0] code;
		case (usage)
			8'h04: code = 8'h1E;  8'h05: code = 8'h30;  8'h06: code = 8'h2E;
			8'h07: code = 8'h20;  8'h08: code = 8'h12;  8'h09: code = 8'h21;
			8'h0A: code = 8'h22;  8'h0B: code = 8'h23;  8'h0C: code = 8'h17;
			8'h0D: code = 8'h24;  8'h0E: code = 8'h25;  8'h0F: code = 8'h26;
			8'h10: code = 8'h32;  8'h11: code = 8'h31;  8'h12: code = 8'h18;
			8'h13: code = 8'h19;  8'h14: code = 8'h10;  8'h15: code = 8'h13;
			8'h16: code = 8'h1F;  8'h17: code = 8'h14;  8'h18: code = 8'h16;
			8'h19: code = 8'h2F;  8'h1A: code = 8'h11;  8'h1B: code = 8'h2D;
			8'h1C: code = 8'h15;  8'h1D: code = 8'h2C;
			8'h1E: code = 8'h02;  8'h1F: code = 8'h03;  8'h20: code = 8'h04;
			8'h21: code = 8'h05;  8'h22: code = 8'h06;  8'h23: code = 8'h07;
			8'h24: code = 8'h08;  8'h25: code = 8'h09;  8'h26: code = 8'h0A;
			8'h27: code = 8'h0B;
			8'h28: code = 8'h1C;  8'h29: code = 8'h01;  8'h2A: code = 8'h0E;
			8'h2B: code = 8'h0F;  8'h2C: code = 8'h39;  8'h2D: code = 8'h0C;
			8'h2E: code = 8'h0D;  8'h2F: code = 8'h1A;  8'h30: code = 8'h1B;
			8'h31: code = 8'h2B;  8'h33: code = 8'h27;  8'h34: code = 8'h28;
			8'h35: code = 8'h29;  8'h36: code = 8'h33;  8'h37: code = 8'h34;
			8'h38: code = 8'h35;  8'h39: code = 8'h3A;
			8'h3A: code = 8'h3B;  8'h3B: code = 8'h3C;  8'h3C: code = 8'h3D;
			8'h3D: code = 8'h3E;  8'h3E: code = 8'h3F;  8'h3F: code = 8'h40;
			8'h40: code = 8'h41;  8'h41: code = 8'h42;  8'h42: code = 8'h43;
			8'h43: code = 8'h44;  8'h44: code = 8'h57;  8'h45: code = 8'h58;
			8'h4A: code = 8'h47;  8'h4B: code = 8'h49;  8'h4D: code = 8'h4F;
			8'h4E: code = 8'h51;  8'h4F: code = 8'h4D;  8'h50: code = 8'h4B;
			8'h51: code = 8'h50;  8'h52: code = 8'h48;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

[rtl/core/hrps_if.sv]
// ----------------------------------------------------------------------------
// hrps_if
// Valid/ready channels of the translator: report words in, scan code words out.
// ----------------------------------------------------------------------------
`default_nettype none

// One boot keyboard report per word; slot n sits in key_slot[8*n+7:8*n].
interface hrps_in_if
	import hrps_pkg::*;
#(
	parameter int KEY_SLOTS = KEY_SLOTS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [7:0]               modifiers;
	logic [8*KEY_SLOTS-1:0]   key_slot;

	modport source (output valid, output modifiers, output key_slot, input ready);
	modport sink   (input valid, input modifiers, input key_slot, output ready);
endinterface

// One PS/2 set 1 byte per word.
interface hrps_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_byte;
	logic       last_of_run;

	modport source (output valid, output scan_byte, output last_of_run, input ready);
	modport sink   (input valid, input scan_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/hid_report_to_ps2_scancodes.sv]
// ----------------------------------------------------------------------------
// hid_report_to_ps2_scancodes
// Translates USB HID boot keyboard reports into PS/2 scan code set 1 bytes.
// ----------------------------------------------------------------------------
// The block takes one report word, compares it with the previous report and
// sends the resulting make, break and E0 prefix bytes one per word, with
// last_of_run set on the final byte of the report; a report that changes
// nothing sends no words. A small sequencer visits the six modifier bits and
// then every key slot twice (releases, then presses), one step per cycle while
// the output side does not stall, through a single match-and-lookup unit; a
// position with an E0 prefix takes an extra step that sends the prefix first.
// The input is not ready until the report is finished.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hid_report_to_ps2_scancodes_macros.svh"

module hid_report_to_ps2_scancodes
	import hrps_pkg::*;
#(
	parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hrps_in_if.sink     rpt,
	hrps_out_if.source  scan
);

	localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int IDX_W  = (SLOT_W > MOD_IDX_W) ? SLOT_W : MOD_IDX_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(KEY_SLOTS - 1);
	localparam logic [IDX_W-1:0] LAST_MOD  = IDX_W'(MOD_COUNT - 1);

	hrps_state_t      state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             pre_q;

	logic [7:0] mods_q;
	logic [7:0] keys_q [KEY_SLOTS];
	logic [7:0] prev_mods_q;
	logic [7:0] prev_keys_q [KEY_SLOTS];

	logic       hold_valid_q;
	logic [7:0] hold_byte_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic              accept, out_pop, step_en;
	logic [SLOT_W-1:0] slot;
	logic [MOD_IDX_W-1:0] mod_i;
	logic [7:0]        probe, probe_code;
	logic              probe_hit, probe_ext, probe_live;
	logic              emit_v, adv, pre_set, phase_last;
	logic [7:0]        emit_b;
	logic              push_mid, push_end;

	// Handshake terms.
	assign accept  = rpt.valid && rpt.ready;
	assign out_pop = out_valid_q && scan.ready;
	assign step_en = !out_valid_q || out_pop;

	assign rpt.ready        = (state_q == ST_IDLE);
	assign scan.valid       = out_valid_q;
	assign scan.scan_byte   = out_byte_q;
	assign scan.last_of_run = out_last_q;

	assign slot  = idx_q[SLOT_W-1:0];
	assign mod_i = idx_q[MOD_IDX_W-1:0];

	// Shared match and lookup unit: releases probe the old slot against the new
	// report, presses probe the new slot against the old report.
	always_comb begin
		probe_hit = 1'b0;
		if (state_q == ST_REL) begin
			probe = prev_keys_q[slot];
			for (int j = 0; j < KEY_SLOTS; j++) begin
				probe_hit = probe_hit | (keys_q[j] == probe);
			end
		end else begin
			probe = keys_q[slot];
			for (int j = 0; j < KEY_SLOTS; j++) begin
				probe_hit = probe_hit | (prev_keys_q[j] == probe);
			end
		end
		probe_code = set1_code(probe);
		probe_ext  = (probe >= EXT_FIRST) && (probe <= EXT_LAST);
		probe_live = (probe != 8'h00) && !probe_hit && (probe_code != 8'h00);
	end

	// Sequencer next state and the byte produced in this step.
	always_comb begin
		state_d    = state_q;
		emit_v     = 1'b0;
		emit_b     = 8'h00;
		adv        = 1'b0;
		pre_set    = 1'b0;
		phase_last = 1'b0;
		if (state_q == ST_IDLE || step_en) begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_d = ST_MOD;
					end
				end
				ST_MOD: begin
					phase_last = (idx_q == LAST_MOD);
					if (|((mods_q ^ prev_mods_q) & MOD_BIT[mod_i])) begin
						emit_v = 1'b1;
						if (MOD_EXT[mod_i] && !pre_q) begin
							emit_b  = EXT_PREFIX;
							pre_set = 1'b1;
						end else begin
							emit_b = (|(mods_q & MOD_BIT[mod_i])) ? MOD_CODE[mod_i]
								: (MOD_CODE[mod_i] | BREAK_BIT);
							adv = 1'b1;
						end
					end else begin
						adv = 1'b1;
					end
					if (adv && phase_last) begin
						state_d = ST_REL;
					end
				end
				ST_REL, ST_PRS: begin
					phase_last = (idx_q == LAST_SLOT);
					if (probe_live) begin
						emit_v = 1'b1;
						if (probe_ext && !pre_q) begin
							emit_b  = EXT_PREFIX;
							pre_set = 1'b1;
						end else begin
							emit_b = (state_q == ST_REL) ? (probe_code | BREAK_BIT)
								: probe_code;
							adv = 1'b1;
						end
					end else begin
						adv = 1'b1;
					end
					if (adv && phase_last) begin
						state_d = (state_q == ST_REL) ? ST_PRS : ST_END;
					end
				end
				ST_END: begin
					state_d = ST_IDLE;
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// A byte leaves the hold register once its successor exists or the run ends.
	assign push_mid = emit_v && hold_valid_q;
	assign push_end = (state_q == ST_END) && step_en && hold_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Position counter and prefix flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pre_q <= 1'b0;
		end else if (accept) begin
			idx_q <= '0;
			pre_q <= 1'b0;
		end else if (adv) begin
			idx_q <= phase_last ? '0 : idx_q + 1'b1;
			pre_q <= 1'b0;
		end else if (pre_set) begin
			pre_q <= 1'b1;
		end
	end

	// Previous report, updated when a report is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= '0;
			end
		end else if (state_q == ST_END && step_en) begin
			prev_mods_q <= mods_q;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_keys_q[i] <= keys_q[i];
			end
		end
	end

	// Current report capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			mods_q <= rpt.modifiers;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				keys_q[i] <= rpt.key_slot[8*i +: 8];
			end
		end
	end

	// Hold and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_v) begin
				hold_valid_q <= 1'b1;
			end else if (push_end) begin
				hold_valid_q <= 1'b0;
			end
			out_valid_q <= push_mid || push_end || (out_valid_q && !out_pop);
		end
	end

	// Hold and output payload.
	always_ff @(posedge clk) begin
		if (emit_v) begin
			hold_byte_q <= emit_b;
		end
		if (push_mid || push_end) begin
			out_byte_q <= hold_byte_q;
			out_last_q <= push_end;
		end
	end

	// Checks on the sequencer.
	`HRPS_ASSERT_NOW(a_idle_no_hold, clk, arst_n, state_q == ST_IDLE, !hold_valid_q)
	`HRPS_ASSERT_NOW(a_prefix_in_run, clk, arst_n, pre_q, (state_q == ST_MOD) || (state_q == ST_REL) || (state_q == ST_PRS))
	`HRPS_ASSERT_NEXT(a_start, clk, arst_n, accept, (state_q == ST_MOD) && (idx_q == '0) && !hold_valid_q)
	`HRPS_ASSERT_NEXT(a_finish, clk, arst_n, (state_q == ST_END) && step_en, (state_q == ST_IDLE) && (prev_mods_q == $past(mods_q)))

endmodule

`default_nettype wire
